### rtl/ksd_pkg.sv
// Shared types and constants for the keyed snapshot difference table.
package ksd_pkg;

	localparam int KSD_TABLE_DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int COUNT_W = 32;
	localparam int OP_W = 2;
	localparam int KIND_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD = 2'd1,
		OP_COMPARE = 2'd2
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED = 2'd0,
		KIND_CHANGED = 2'd1,
		KIND_FULL = 2'd2
	} kind_t;

endpackage

### rtl/ksd_in_if.sv
// Input channel carrying one table operation per transaction.
interface ksd_in_if
	import ksd_pkg::*;
();
	logic valid;
	logic ready;
	logic [OP_W-1:0] opcode;
	logic [KEY_W-1:0] story_id;
	logic [COUNT_W-1:0] change_count;

	modport source (output valid, output opcode, output story_id, output change_count,
		input ready);
	modport sink (input valid, input opcode, input story_id, input change_count,
		output ready);
endinterface

### rtl/ksd_out_if.sv
// Output channel carrying one difference row per transaction.
interface ksd_out_if
	import ksd_pkg::*;
();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] row_kind;
	logic [KEY_W-1:0] row_id;
	logic [COUNT_W-1:0] source_count;
	logic [COUNT_W-1:0] target_count;

	modport source (output valid, output row_kind, output row_id, output source_count,
		output target_count, input ready);
	modport sink (input valid, input row_kind, input row_id, input source_count,
		input target_count, output ready);
endinterface

### rtl/ksd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ksd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/ksd_cam.sv
// Key store with parallel match, fill level and in-order slot allocation.
module ksd_cam
	import ksd_pkg::*;
#(
	parameter int DEPTH = KSD_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic [KEY_W-1:0] key,
	input logic clr,
	input logic ins,
	output logic hit,
	output logic [$clog2(DEPTH)-1:0] hit_idx,
	output logic [$clog2(DEPTH)-1:0] new_idx,
	output logic full
);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [KEY_W-1:0] key_q [DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [DEPTH-1:0] match;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (FILL_W'(i) < fill_q) && (key_q[i] == key);
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit = |match;
	assign full = (fill_q == FILL_W'(DEPTH));
	assign new_idx = fill_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clr) begin
			fill_q <= '0;
		end else if (ins) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			key_q[new_idx] <= key;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(match))
		else $error("More than one valid slot holds the same key.");
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_W'(DEPTH))
		else $error("Fill level exceeds the table depth.");
	assert property (@(posedge clk) disable iff (!arst_n) ins |-> !full && !hit && !clr)
		else $error("Insert into a full table or of a key already present.");
endmodule

### rtl/keyed_snapshot_diff_table.sv
// Top level of the keyed snapshot difference table.
// Operations pass the input and lookup registers; a row then fills the output register.
// Throughput: one transaction per cycle while the output takes rows, set by the parallel
// key match, which is combinational, and the registered read of the count memory.
// Reset clears the fill level and all pipeline valid flags; key and count storage are
// not reset and need no clearing pass, since only slots below the fill level are matched.
module keyed_snapshot_diff_table
	import ksd_pkg::*;
#(
	parameter int TABLE_DEPTH = KSD_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	ksd_in_if.sink items,
	ksd_out_if.source rows
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic v_s1;
	logic [OP_W-1:0] op_s1;
	logic [KEY_W-1:0] id_s1;
	logic [COUNT_W-1:0] cnt_s1;

	logic v_s2;
	logic full_s2;
	logic miss_s2;
	logic cmphit_s2;
	logic [KEY_W-1:0] id_s2;
	logic [COUNT_W-1:0] cnt_s2;

	logic out_v_q;
	kind_t out_kind_q;
	logic [KEY_W-1:0] out_id_q;
	logic [COUNT_W-1:0] out_src_q;
	logic [COUNT_W-1:0] out_tgt_q;

	logic hit;
	logic full;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] new_idx;
	logic is_clr;
	logic is_load;
	logic is_cmp;
	logic adv1;
	logic s2_free;
	logic s2_res;
	logic out_free;
	logic out_load;
	logic ram_we;
	logic cam_ins;
	logic [IDX_W-1:0] ram_waddr;
	logic [COUNT_W-1:0] ram_rdata;

	assign is_clr = (op_s1 == OP_CLEAR);
	assign is_load = (op_s1 == OP_LOAD);
	assign is_cmp = (op_s1 == OP_COMPARE);

	assign out_free = !out_v_q || rows.ready;
	assign s2_res = full_s2 || miss_s2 || (cmphit_s2 && (ram_rdata != cnt_s2));
	assign s2_free = !v_s2 || !s2_res || out_free;
	assign out_load = v_s2 && s2_res && out_free;
	assign adv1 = v_s1 && s2_free;
	assign items.ready = !v_s1 || s2_free;

	assign cam_ins = adv1 && is_load && !hit && !full;
	assign ram_we = adv1 && is_load && (hit || !full);
	assign ram_waddr = hit ? hit_idx : new_idx;

	ksd_cam #(
		.DEPTH(TABLE_DEPTH)
	) u_cam (
		.clk(clk),
		.arst_n(arst_n),
		.key(id_s1),
		.clr(adv1 && is_clr),
		.ins(cam_ins),
		.hit(hit),
		.hit_idx(hit_idx),
		.new_idx(new_idx),
		.full(full)
	);

	ksd_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(TABLE_DEPTH)
	) u_count_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(cnt_s1),
		.re(adv1),
		.raddr(hit_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (items.valid && items.ready) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (s2_free) begin
				v_s2 <= adv1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rows.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1 <= items.opcode;
			id_s1 <= items.story_id;
			cnt_s1 <= items.change_count;
		end
		if (adv1) begin
			full_s2 <= is_load && !hit && full;
			miss_s2 <= is_cmp && !hit;
			cmphit_s2 <= is_cmp && hit;
			id_s2 <= id_s1;
			cnt_s2 <= cnt_s1;
		end
		if (out_load) begin
			priority if (full_s2) begin
				out_kind_q <= KIND_FULL;
			end else if (miss_s2) begin
				out_kind_q <= KIND_ADDED;
			end else begin
				out_kind_q <= KIND_CHANGED;
			end
			out_id_q <= id_s2;
			out_src_q <= (full_s2 || miss_s2) ? '0 : ram_rdata;
			out_tgt_q <= cnt_s2;
		end
	end

	assign rows.valid = out_v_q;
	assign rows.row_kind = out_kind_q;
	assign rows.row_id = out_id_q;
	assign rows.source_count = out_src_q;
	assign rows.target_count = out_tgt_q;

	assert property (@(posedge clk) disable iff (!arst_n) (out_v_q && !rows.ready) |-> !out_load)
		else $error("Pending row overwritten before it was taken.");
	assert property (@(posedge clk) disable iff (!arst_n) (adv1 && !is_load) |-> !ram_we)
		else $error("Count memory written by an operation other than a load.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && v_s1) |-> adv1)
		else $error("Transaction accepted while the input register is held.");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $countones({full_s2, miss_s2, cmphit_s2}) <= 1)
		else $error("Lookup stage carries conflicting outcomes.");
endmodule

### test/keyed_snapshot_diff_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyed snapshot difference table.
module keyed_snapshot_diff_table_tb;
	import ksd_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int PRESSURE_ITEMS = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_DIRECTED = 22;

	typedef struct {
		kind_t kind;
		logic [KEY_W-1:0] id;
		logic [COUNT_W-1:0] src;
		logic [COUNT_W-1:0] tgt;
	} diff_row_t;

	typedef enum {RULE_MODEL, RULE_NONE, RULE_ROW} row_rule_t;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] id;
		logic [COUNT_W-1:0] cnt;
		row_rule_t rule;
		kind_t kind;
		logic [COUNT_W-1:0] src;
	} directed_item_t;

	directed_item_t directed_items [N_DIRECTED] = '{
		'{OP_COMPARE, 32'h0000_0000, 32'h0000_0000, RULE_ROW, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RULE_ROW, KIND_ADDED, 32'h0},
		'{OP_LOAD, 32'h0000_0000, 32'h0000_0000, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_LOAD, 32'h1234_5678, 32'h8000_0000, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h0000_0000, 32'h0000_0000, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'hFFFF_FFFF, 32'h0000_0000, RULE_ROW, KIND_CHANGED, 32'hFFFF_FFFF},
		'{OP_COMPARE, 32'h0000_0000, 32'hFFFF_FFFF, RULE_ROW, KIND_CHANGED, 32'h0},
		'{OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0001, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'hFFFF_FFFF, 32'h0000_0001, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h1234_5678, 32'h7FFF_FFFF, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h1234_5678, 32'h8000_0000, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_UNUSED, 32'h0000_0000, 32'h0000_0000, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h0000_0000, 32'h0000_0000, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RULE_NONE, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h0000_0000, 32'h0000_0000, RULE_ROW, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'hFFFF_FFFF, 32'h0000_0001, RULE_ROW, KIND_ADDED, 32'h0},
		'{OP_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'hAAAA_AAAA, 32'h5555_5554, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_COMPARE, 32'h5555_5555, 32'hAAAA_AAAA, RULE_MODEL, KIND_ADDED, 32'h0},
		'{OP_CLEAR, 32'h0000_0000, 32'h0000_0000, RULE_NONE, KIND_ADDED, 32'h0}
	};

	logic clk;
	logic arst_n;

	ksd_in_if items_if();
	ksd_out_if rows_if();

	keyed_snapshot_diff_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.rows(rows_if)
	);

	logic [KEY_W-1:0] table_keys [KSD_TABLE_DEPTH];
	logic [COUNT_W-1:0] table_counts [KSD_TABLE_DEPTH];
	int table_fill = 0;

	diff_row_t pending_rows [$];
	int failures = 0;
	int sent_items = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int find_slot(input logic [KEY_W-1:0] id);
		int slot;
		slot = -1;
		for (int i = 0; i < table_fill; i++) begin
			if (slot < 0 && table_keys[i] == id) slot = i;
		end
		return slot;
	endfunction

	function automatic bit predict_diff_row(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] id, input logic [COUNT_W-1:0] cnt, output diff_row_t row);
		int slot;
		slot = find_slot(id);
		row = '{KIND_ADDED, id, 32'd0, cnt};
		case (op)
			OP_CLEAR: begin
				table_fill = 0;
				return 1'b0;
			end
			OP_LOAD: begin
				if (slot >= 0) begin
					table_counts[slot] = cnt;
					return 1'b0;
				end
				if (table_fill < KSD_TABLE_DEPTH) begin
					table_keys[table_fill] = id;
					table_counts[table_fill] = cnt;
					table_fill++;
					return 1'b0;
				end
				row.kind = KIND_FULL;
				return 1'b1;
			end
			OP_COMPARE: begin
				if (slot < 0) return 1'b1;
				if (table_counts[slot] != cnt) begin
					row.kind = KIND_CHANGED;
					row.src = table_counts[slot];
					return 1'b1;
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void queue_row(input diff_row_t row);
		pending_rows = {pending_rows, row};
	endfunction

	task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] id,
			input logic [COUNT_W-1:0] cnt, output bit has_row, output diff_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.opcode <= op;
		items_if.story_id <= id;
		items_if.change_count <= cnt;
		do @(posedge clk); while (!items_if.ready);
		has_row = predict_diff_row(op, id, cnt, row);
		if (op != OP_UNUSED) sent_items++;
		@(negedge clk);
	endtask

	task automatic offer_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] id,
			input logic [COUNT_W-1:0] cnt);
		bit has_row;
		diff_row_t row;
		send_op(op, id, cnt, has_row, row);
		if (has_row) queue_row(row);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int stored_pct);
		if (table_fill > 0 && $urandom_range(99) < stored_pct)
			return table_keys[$urandom_range(table_fill - 1)];
		if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
		return $urandom;
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
		return $urandom;
	endfunction

	task automatic run_sequence(input bit fill_up);
		int n_loads;
		int slot;
		logic [KEY_W-1:0] id;
		if (fill_up || $urandom_range(3) == 0) offer_item(OP_CLEAR, $urandom, $urandom);
		if (fill_up) n_loads = KSD_TABLE_DEPTH + 3;
		else if ($urandom_range(7) == 0) n_loads = $urandom_range(40, 70);
		else n_loads = $urandom_range(1, 10);
		repeat (n_loads) offer_item(OP_LOAD, pick_key(fill_up ? 0 : 25), pick_count());
		if (fill_up) repeat (3) offer_item(OP_LOAD, pick_key(100), pick_count());
		repeat ($urandom_range(2, 14)) begin
			id = pick_key(70);
			slot = find_slot(id);
			if (slot >= 0 && $urandom_range(1) == 0)
				offer_item(OP_COMPARE, id, table_counts[slot]);
			else
				offer_item(OP_COMPARE, id, pick_count());
		end
		if ($urandom_range(4) == 0) offer_item(OP_W'($urandom_range(3)), $urandom, $urandom);
	endtask

	initial begin
		rows_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rows_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				rows_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		diff_row_t want;
		if (arst_n && rows_if.valid && rows_if.ready) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row, expected none, actual kind %0d id %h src %h tgt %h",
					$time, rows_if.row_kind, rows_if.row_id, rows_if.source_count,
					rows_if.target_count);
				failures++;
			end else begin
				want = pending_rows.pop_front();
				check_field("row_kind", 32'(want.kind), 32'(rows_if.row_kind));
				check_field("row_id", want.id, rows_if.row_id);
				check_field("source_count", want.src, rows_if.source_count);
				check_field("target_count", want.tgt, rows_if.target_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (rows_if.valid && rows_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("keyed_snapshot_diff_table regression: fail");
			$finish;
		end
	end

	initial begin
		bit has_row;
		diff_row_t row;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.opcode = OP_CLEAR;
		items_if.story_id = '0;
		items_if.change_count = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_items[i]) begin
			send_op(directed_items[i].op, directed_items[i].id, directed_items[i].cnt,
				has_row, row);
			case (directed_items[i].rule)
				RULE_MODEL: if (has_row) queue_row(row);
				RULE_ROW: queue_row('{directed_items[i].kind, directed_items[i].id,
					directed_items[i].src, directed_items[i].cnt});
				default: ;
			endcase
		end

		run_sequence(1'b1);
		while (sent_items < 240) run_sequence(1'b0);

		hold_req = 1'b1;
		repeat (PRESSURE_ITEMS) offer_item(OP_COMPARE, $urandom, $urandom);

		send_idle_pct = 77;
		while (sent_items < 460) run_sequence(1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		while (sent_items < 680) run_sequence(1'b0);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		while (sent_items < 940) run_sequence(1'b0);

		items_if.valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("keyed_snapshot_diff_table regression: pass");
		else
			$display("keyed_snapshot_diff_table regression: fail");
		$finish;
	end

endmodule
